// ===== hw/rtl/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge address mapper package
// Shared widths, codes and pipeline beat types for the cartridge decoder.
// ----------------------------------------------------------------------------
package cam_pkg;

  // Offset space of the cartridge memories
  localparam int unsigned ROM_OFFSET_BITS  = 23;
  localparam int unsigned SRAM_OFFSET_BITS = 17;

  // Field and register widths
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned OFFSET_W    = 23;
  localparam int unsigned ROM_SIZE_W  = 24;
  localparam int unsigned SRAM_SIZE_W = 18;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;

  // Remainder unit: the divisor holds a size up to 2^ROM_OFFSET_BITS
  localparam int unsigned DSR_W = ROM_OFFSET_BITS + 1;
  // Widest wrapping offset before reduction is 22 bits, in the LoROM and HiROM ROM regions
  localparam int unsigned DVD_W          = 22;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned MOD_STAGES     = DVD_W / BITS_PER_STAGE;

  localparam logic [ROM_SIZE_W-1:0]  ROM_LIM_MAX  = ROM_SIZE_W'(1) << ROM_OFFSET_BITS;
  localparam logic [SRAM_SIZE_W-1:0] SRAM_LIM_MAX = SRAM_SIZE_W'(1) << SRAM_OFFSET_BITS;

  typedef enum logic [2:0] {
    TGT_WRAM = 3'd0,
    TGT_IO   = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_SRAM = 3'd3,
    TGT_NONE = 3'd4
  } tgt_e;

  typedef enum logic [1:0] {
    MAP_LOROM   = 2'd0,
    MAP_HIROM   = 2'd1,
    MAP_EXHIROM = 2'd2,
    MAP_NONE    = 2'd3
  } map_e;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAP_MODE  = 2'd0;
  localparam cfg_idx_t CFG_ROM_SIZE  = 2'd1;
  localparam cfg_idx_t CFG_SRAM_SIZE = 2'd2;

  typedef struct packed {
    map_e             mode;
    logic [DSR_W-1:0] rom_lim;
    logic [DSR_W-1:0] sram_lim;
  } cam_cfg_t;

  typedef struct packed {
    tgt_e             target;
    logic             do_mod;
    logic [DVD_W-1:0] dvd;
    logic [DSR_W-1:0] dsr;
    logic [DSR_W-1:0] rem;
  } cam_beat_t;

endpackage

// ===== hw/rtl/cam_req_if.sv =====
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel carrying one bus access per beat.
// ----------------------------------------------------------------------------
interface cam_req_if
  import cam_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] bus_address;

  modport source (output valid, output opcode, output bus_address, input ready);
  modport sink   (input valid, input opcode, input bus_address, output ready);
endinterface

// ===== hw/rtl/cam_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Decode result channel
// Valid/ready channel carrying one target and offset per beat.
// ----------------------------------------------------------------------------
interface cam_rsp_if
  import cam_pkg::*;
();
  logic                valid;
  logic                ready;
  tgt_e                target;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, output target, output offset, input ready);
  modport sink   (input valid, input target, input offset, output ready);
endinterface

// ===== hw/rtl/cam_decode.sv =====
// ----------------------------------------------------------------------------
// Cartridge address decode stage
// Classifies the access and registers a beat for the remainder pipeline.
// ----------------------------------------------------------------------------
module cam_decode
  import cam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [ADDR_W-1:0] bus_address_i,
  input  cam_cfg_t          cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cam_beat_t         out_beat_o
);

  logic [7:0]          bank;
  logic [15:0]         off;
  logic                sys;
  logic                want_sram;
  logic                want_wrap;
  logic                want_bound;
  logic [DVD_W-1:0]    sram_raw;
  logic [DVD_W-1:0]    wrap_raw;
  logic [OFFSET_W-1:0] bound_raw;
  cam_beat_t           beat_d;
  cam_beat_t           beat_q;
  logic                valid_q;

  assign bank = bus_address_i[23:16];
  assign off  = bus_address_i[15:0];
  assign sys  = bank inside {[8'h00:8'h3F], [8'h80:8'hBF]};

  // Cartridge region per layout
  always_comb begin
    want_sram  = 1'b0;
    want_wrap  = 1'b0;
    want_bound = 1'b0;
    sram_raw   = '0;
    wrap_raw   = '0;
    bound_raw  = '0;
    case (cfg_i.mode)
      MAP_LOROM: begin
        if (!off[15]) begin
          want_sram = bank inside {[8'h70:8'h7D], [8'hF0:8'hFF]};
          sram_raw  = DVD_W'({bank[3:0], off[14:0]});
        end else begin
          want_wrap = 1'b1;
          wrap_raw  = DVD_W'({bank[6:0], off[14:0]});
        end
      end
      MAP_HIROM: begin
        if ((bank inside {[8'h20:8'h3F], [8'hA0:8'hBF]}) &&
            (off inside {[16'h6000:16'h7FFF]})) begin
          want_sram = 1'b1;
          sram_raw  = DVD_W'({bank[4:0], off[12:0]});
        end else if ((bank >= 8'hC0) || (bank inside {[8'h40:8'h7D]}) || off[15]) begin
          want_wrap = 1'b1;
          wrap_raw  = DVD_W'({bank[5:0], off});
        end
      end
      MAP_EXHIROM: begin
        if ((bank inside {[8'h20:8'h3F]}) && (off inside {[16'h6000:16'h7FFF]})) begin
          want_sram = 1'b1;
          sram_raw  = DVD_W'({bank[4:0], off[12:0]});
        end else if (bank >= 8'hC0) begin
          want_bound = 1'b1;
          bound_raw  = OFFSET_W'({bank[5:0], off});
        end else if (off[15] && (bank inside {[8'h80:8'hBF]})) begin
          want_bound = 1'b1;
          bound_raw  = OFFSET_W'({2'b10, bank[5:0], off[14:0]});
        end else if (off[15] && (bank <= 8'h3F)) begin
          want_bound = 1'b1;
          bound_raw  = OFFSET_W'({2'b11, bank[5:0], off[14:0]});
        end
      end
      default: begin
      end
    endcase
  end

  // System areas take priority over the cartridge
  always_comb begin
    beat_d        = '0;
    beat_d.target = TGT_NONE;
    if (bank == 8'h7E || bank == 8'h7F) begin
      beat_d.target = TGT_WRAM;
      beat_d.rem    = DSR_W'({bank[0], off});
    end else if (sys && (off inside {[16'h2000:16'h5FFF]})) begin
      beat_d.target = TGT_IO;
      beat_d.rem    = DSR_W'(off);
    end else if (sys && off < 16'h2000) begin
      beat_d.target = TGT_WRAM;
      beat_d.rem    = DSR_W'(off);
    end else if (want_sram && cfg_i.sram_lim != '0) begin
      beat_d.target = TGT_SRAM;
      beat_d.do_mod = 1'b1;
      beat_d.dvd    = sram_raw;
      beat_d.dsr    = cfg_i.sram_lim;
    end else if (want_wrap && !opcode_i && cfg_i.rom_lim != '0) begin
      beat_d.target = TGT_ROM;
      beat_d.do_mod = 1'b1;
      beat_d.dvd    = wrap_raw;
      beat_d.dsr    = cfg_i.rom_lim;
    end else if (want_bound && !opcode_i &&
                 ({1'b0, bound_raw} < (OFFSET_W + 1)'(cfg_i.rom_lim))) begin
      beat_d.target = TGT_ROM;
      beat_d.rem    = DSR_W'(bound_raw);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ===== hw/rtl/cam_mod_stage.sv =====
// ----------------------------------------------------------------------------
// Remainder pipeline stage
// Retires BITS_PER_STAGE restoring-division steps of the offset wrap.
// ----------------------------------------------------------------------------
module cam_mod_stage
  import cam_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cam_beat_t in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cam_beat_t out_beat_o
);

  cam_beat_t beat_d;
  cam_beat_t beat_q;
  logic      valid_q;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    logic [DSR_W-1:0] r;
    beat_d = in_beat_i;
    r      = in_beat_i.rem;
    if (in_beat_i.do_mod) begin
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        r = {r[DSR_W-2:0], beat_d.dvd[DVD_W-1]};
        if (r >= beat_d.dsr) begin
          r = r - beat_d.dsr;
        end
        beat_d.dvd = beat_d.dvd << 1;
      end
      beat_d.rem = r;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ===== hw/rtl/cartridge_address_mapper.sv =====
// ----------------------------------------------------------------------------
// Cartridge address mapper
// Decodes a 24-bit bus access into a memory target and a byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one access per beat (opcode: read or write, bus_address).
//   rsp_o returns one beat per access, in order: target (work RAM, I/O, ROM,
//   SRAM or none) and the offset within that target; none gives offset 0.
//   The layout and the ROM and SRAM sizes are set on the write port
//   (cfg_we_i, cfg_index_i, cfg_data_i) while no access is in flight.
// Pipeline: the decode register loads at the edge that accepts a request,
//   then eleven stages of the remainder pipeline wrap ROM and SRAM
//   offsets modulo the configured size, two quotient bits per stage; the
//   last stage register raises the result.
// Throughput: one access per cycle, sustained while rsp_o.ready stays high.
// Reset: the layout comes up as none and both sizes as zero, so all
//   cartridge space decodes as none; the pipeline empties.
// Stall: each stage holds its beat while the one after it is full and
//   stalled; empty stages keep filling, so up to twelve beats queue up
//   before req_i.ready drops. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cartridge_address_mapper
  import cam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cam_req_if.sink               req_i,
  cam_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  map_e                   map_q;
  logic [ROM_SIZE_W-1:0]  rom_size_q;
  logic [SRAM_SIZE_W-1:0] sram_size_q;
  cam_cfg_t               cfg;

  cam_beat_t beat [MOD_STAGES+1];
  logic      vld  [MOD_STAGES+1];
  logic      rdy  [MOD_STAGES+1];

  // Configuration registers; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= MAP_NONE;
      rom_size_q  <= '0;
      sram_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_MODE:  map_q       <= map_e'(cfg_data_i[1:0]);
        CFG_ROM_SIZE:  rom_size_q  <= cfg_data_i[ROM_SIZE_W-1:0];
        CFG_SRAM_SIZE: sram_size_q <= cfg_data_i[SRAM_SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp oversized memories to the offset space
  always_comb begin
    cfg.mode     = map_q;
    cfg.rom_lim  = (rom_size_q > ROM_LIM_MAX) ? DSR_W'(ROM_LIM_MAX) : DSR_W'(rom_size_q);
    cfg.sram_lim = (sram_size_q > SRAM_LIM_MAX) ? DSR_W'(SRAM_LIM_MAX)
                                                : DSR_W'(sram_size_q);
  end

  // Decode stage
  cam_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (req_i.ready),
    .opcode_i      (req_i.opcode),
    .bus_address_i (req_i.bus_address),
    .cfg_i         (cfg),
    .out_valid_o   (vld[0]),
    .out_ready_i   (rdy[0]),
    .out_beat_o    (beat[0])
  );

  // Remainder pipeline; beats that need no wrap pass through untouched
  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    cam_mod_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[s]),
      .in_ready_o  (rdy[s]),
      .in_beat_i   (beat[s]),
      .out_valid_o (vld[s+1]),
      .out_ready_i (rdy[s+1]),
      .out_beat_o  (beat[s+1])
    );
  end

  // Last stage register drives the result channel
  assign rsp_o.valid     = vld[MOD_STAGES];
  assign rdy[MOD_STAGES] = rsp_o.ready;
  assign rsp_o.target    = beat[MOD_STAGES].target;
  assign rsp_o.offset    = OFFSET_W'(beat[MOD_STAGES].rem);

  // An unmapped access carries no offset
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.target == TGT_NONE |-> rsp_o.offset == '0)
    else $error("unmapped result with non-zero offset");

  // A ROM hit lies inside the clamped ROM size
  a_rom_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.target == TGT_ROM
      |-> {1'b0, rsp_o.offset} < (OFFSET_W + 1)'(cfg.rom_lim))
    else $error("ROM offset beyond ROM size");

  // An SRAM hit lies inside the clamped SRAM size
  a_sram_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.target == TGT_SRAM
      |-> {1'b0, rsp_o.offset} < (OFFSET_W + 1)'(cfg.sram_lim))
    else $error("SRAM offset beyond SRAM size");

  // I/O offsets stay in the register window
  a_io_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.target == TGT_IO
      |-> rsp_o.offset >= OFFSET_W'(16'h2000) && rsp_o.offset <= OFFSET_W'(16'h5FFF))
    else $error("I/O offset outside register window");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Cartridge address mapper testbench
// Drives bus accesses through the decoder under every layout and a spread of
// ROM and SRAM sizes. Each response beat is checked against a local decode.
// ----------------------------------------------------------------------------
module testbench
  import cam_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Access kinds on the request channel
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register index past the end of the map: the block ignores it
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // Quiet cycles (no beat on either side, no register write) before giving up
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles to wait after the last response: pipeline depth plus margin
  localparam int unsigned TAIL_CYCLES = 20;
  // Length of the forced response hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 120;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] bus_address;
  } bus_access_t;

  typedef struct packed {
    tgt_e                target;
    logic [OFFSET_W-1:0] offset;
  } decode_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cam_req_if req ();
  cam_rsp_if rsp ();

  cartridge_address_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Local copy of the layout registers, at their reset values
  map_e                   cfg_mode      = MAP_NONE;
  logic [ROM_SIZE_W-1:0]  cfg_rom_size  = '0;
  logic [SRAM_SIZE_W-1:0] cfg_sram_size = '0;

  bus_access_t access_pending[$];
  decode_t     expected_decodes[$];
  bus_access_t next_access;
  decode_t     head_decode;

  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct  = 9;
  int unsigned sink_idle_pct = 9;
  int unsigned stall_req  = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;
  logic        req_fired  = 1'b0;

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decode prediction
  // --------------------------------------------------------------------------
  function automatic decode_t hit(input tgt_e tgt, input int unsigned ofs);
    decode_t res;
    res.target = tgt;
    res.offset = OFFSET_W'(ofs);
    return res;
  endfunction

  // ROM region that wraps modulo its size; writes and a missing ROM land nowhere
  function automatic decode_t rom_wrapped(input logic wr, input int unsigned raw,
                                          input int unsigned lim);
    if (wr || lim == 0) return hit(TGT_NONE, 0);
    return hit(TGT_ROM, raw % lim);
  endfunction

  // ROM region that ends at its size (extended layout)
  function automatic decode_t rom_bounded(input logic wr, input int unsigned raw,
                                          input int unsigned lim);
    if (wr || raw >= lim) return hit(TGT_NONE, 0);
    return hit(TGT_ROM, raw);
  endfunction

  function automatic decode_t sram_wrapped(input int unsigned raw, input int unsigned lim);
    if (lim == 0) return hit(TGT_NONE, 0);
    return hit(TGT_SRAM, raw % lim);
  endfunction

  function automatic decode_t decode_access(input logic opcode,
                                            input logic [ADDR_W-1:0] addr);
    decode_t     res;
    int unsigned bank;
    int unsigned off;
    int unsigned rom_lim;
    int unsigned sram_lim;
    logic        wr;
    logic        sys_bank;
    logic        hi_win;
    bank     = addr[23:16];
    off      = addr[15:0];
    wr       = (opcode == OP_WRITE);
    // Clamp oversized sizes to the offset space of each memory
    rom_lim  = (cfg_rom_size > ROM_LIM_MAX) ? ROM_LIM_MAX : cfg_rom_size;
    sram_lim = (cfg_sram_size > SRAM_LIM_MAX) ? SRAM_LIM_MAX : cfg_sram_size;
    sys_bank = (bank <= 'h3F) || (bank >= 'h80 && bank <= 'hBF);
    hi_win   = (off >= 'h6000) && (off <= 'h7FFF);
    res      = hit(TGT_NONE, 0);

    // Work RAM and I/O decode the same way whatever the layout
    if (bank == 'h7E || bank == 'h7F) begin
      res = hit(TGT_WRAM, (bank & 1) * 'h10000 + off);
    end else if (sys_bank && off >= 'h2000 && off <= 'h5FFF) begin
      res = hit(TGT_IO, off);
    end else if (sys_bank && off < 'h2000) begin
      res = hit(TGT_WRAM, off);
    end else begin
      case (cfg_mode)
        MAP_LOROM: begin
          if (off >= 'h8000) begin
            res = rom_wrapped(wr, (bank & 'h7F) * 'h8000 + off - 'h8000, rom_lim);
          end else if ((bank >= 'h70 && bank <= 'h7D) || bank >= 'hF0) begin
            res = sram_wrapped((bank & 'h0F) * 'h8000 + off, sram_lim);
          end
        end
        MAP_HIROM: begin
          if (((bank >= 'h20 && bank <= 'h3F) || (bank >= 'hA0 && bank <= 'hBF)) && hi_win) begin
            res = sram_wrapped((bank & 'h1F) * 'h2000 + off - 'h6000, sram_lim);
          end else if (bank >= 'hC0 || (bank >= 'h40 && bank <= 'h7D) || off >= 'h8000) begin
            res = rom_wrapped(wr, (bank & 'h3F) * 'h10000 + off, rom_lim);
          end
        end
        MAP_EXHIROM: begin
          if (bank >= 'h20 && bank <= 'h3F && hi_win) begin
            res = sram_wrapped((bank - 'h20) * 'h2000 + off - 'h6000, sram_lim);
          end else if (bank >= 'hC0) begin
            res = rom_bounded(wr, (bank - 'hC0) * 'h10000 + off, rom_lim);
          end else if (off >= 'h8000 && bank >= 'h80 && bank <= 'hBF) begin
            res = rom_bounded(wr, 'h400000 + (bank - 'h80) * 'h8000 + off - 'h8000, rom_lim);
          end else if (off >= 'h8000 && bank <= 'h3F) begin
            res = rom_bounded(wr, 'h600000 + bank * 'h8000 + off - 'h8000, rom_lim);
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Bias addresses towards region edges; a quarter stay fully random
  function automatic logic [ADDR_W-1:0] rand_address();
    logic [7:0]  bank;
    logic [15:0] off;
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom);
    bank = 8'($urandom);
    off  = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 17))
        0:  bank = 8'h00;
        1:  bank = 8'h1F;
        2:  bank = 8'h20;
        3:  bank = 8'h3F;
        4:  bank = 8'h40;
        5:  bank = 8'h6F;
        6:  bank = 8'h70;
        7:  bank = 8'h7D;
        8:  bank = 8'h7E;
        9:  bank = 8'h7F;
        10: bank = 8'h80;
        11: bank = 8'h9F;
        12: bank = 8'hA0;
        13: bank = 8'hBF;
        14: bank = 8'hC0;
        15: bank = 8'hEF;
        16: bank = 8'hF0;
        default: bank = 8'hFF;
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0: off = 16'h0000;
        1: off = 16'h1FFF;
        2: off = 16'h2000;
        3: off = 16'h5FFF;
        4: off = 16'h6000;
        5: off = 16'h7FFF;
        6: off = 16'h8000;
        default: off = 16'hFFFF;
      endcase
    end
    return {bank, off};
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: advance to the next access once the current beat is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req.valid || req_fired) begin
        if (access_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_access     = access_pending.pop_front();
          req.valid       <= 1'b1;
          req.opcode      <= next_access.opcode;
          req.bus_address <= next_access.bus_address;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response sink: random back-pressure, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= HOLD_OFF_CYCLES;
      rsp.ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted access, check every response beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        expected_decodes.push_back(decode_access(req.opcode, req.bus_address));
        accepted_cnt++;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_decodes.size() == 0) begin
          $error("unexpected response beat: target %0d offset 0x%06h",
                 rsp.target, rsp.offset);
          err_cnt++;
        end else begin
          head_decode = expected_decodes.pop_front();
          if (rsp.target !== head_decode.target) begin
            $error("target: expected %0d, got %0d", head_decode.target, rsp.target);
            err_cnt++;
          end
          if (rsp.offset !== head_decode.offset) begin
            $error("offset: expected 0x%06h, got 0x%06h", head_decode.offset, rsp.offset);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: drop out if the channels go quiet for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("cartridge_address_mapper: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_access(input logic opcode, input logic [ADDR_W-1:0] addr);
    bus_access_t acc;
    acc.opcode      = opcode;
    acc.bus_address = addr;
    access_pending.push_back(acc);
    pushed_cnt++;
  endtask

  // Hold until every queued access has been taken and answered
  task automatic drain();
    while (access_pending.size() != 0 || accepted_cnt != pushed_cnt ||
           expected_decodes.size() != 0)
      @(negedge clk_i);
  endtask

  // Write one register and mirror it locally; the block is idle here
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_MAP_MODE:  cfg_mode      = map_e'(data[1:0]);
      CFG_ROM_SIZE:  cfg_rom_size  = data[ROM_SIZE_W-1:0];
      CFG_SRAM_SIZE: cfg_sram_size = data[SRAM_SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input map_e mode, input logic [ROM_SIZE_W-1:0] rom_sz,
                           input logic [SRAM_SIZE_W-1:0] sram_sz);
    write_reg(CFG_MAP_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_ROM_SIZE, CFG_DATA_W'(rom_sz));
    write_reg(CFG_SRAM_SIZE, CFG_DATA_W'(sram_sz));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned            phase;
    logic [ROM_SIZE_W-1:0]  rom_sz;
    logic [SRAM_SIZE_W-1:0] sram_sz;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_MAP_MODE;
    cfg_data_i      = '0;
    req.valid       = 1'b0;
    req.opcode      = OP_READ;
    req.bus_address = '0;
    rsp.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset layout: only work RAM and I/O decode, cartridge space is empty
    push_access(OP_READ,  24'h00_0000);
    push_access(OP_WRITE, 24'h7F_FFFF);
    push_access(OP_READ,  24'h80_2000);
    push_access(OP_READ,  24'hC0_0000);
    push_access(OP_READ,  24'h00_8000);
    drain();

    // LoROM, ROM size not a power of two, small SRAM
    configure(MAP_LOROM, 24'h06_0000, 18'h0800);
    push_access(OP_READ,  24'h80_8000);
    push_access(OP_READ,  24'hFF_FFFF);
    push_access(OP_READ,  24'h70_0000);
    push_access(OP_READ,  24'hF0_7FFF);
    push_access(OP_WRITE, 24'h00_8000);   // write into ROM lands nowhere
    push_access(OP_READ,  24'h40_0000);   // unmapped low half
    drain();

    // HiROM with both sizes beyond their offset space
    configure(MAP_HIROM, 24'hFF_FFFF, 18'h3_FFFF);
    push_access(OP_READ,  24'hC0_0000);
    push_access(OP_READ,  24'hFF_FFFF);
    push_access(OP_READ,  24'h3F_6000);
    push_access(OP_WRITE, 24'hBF_7FFF);
    push_access(OP_READ,  24'h7D_1234);
    push_access(OP_WRITE, 24'h40_0000);
    drain();

    // ExHiROM: ROM bounded rather than wrapped, no SRAM fitted
    configure(MAP_EXHIROM, 24'h50_0000, 18'h0);
    push_access(OP_READ,  24'hC0_0000);
    push_access(OP_READ,  24'hFF_FFFF);
    push_access(OP_READ,  24'h80_8000);
    push_access(OP_READ,  24'hBF_FFFF);   // past the end of ROM
    push_access(OP_READ,  24'h00_8000);
    push_access(OP_READ,  24'h20_6000);
    push_access(OP_WRITE, 24'hC0_0000);
    drain();

    // Random phases: sweep layouts against extreme and random sizes
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: rom_sz = '0;
        1: rom_sz = 24'h80_0000;
        2: rom_sz = 24'hFF_FFFF;
        3: rom_sz = 24'h1;
        4: rom_sz = ROM_SIZE_W'($urandom_range(1, 24'h80_0000));
        default: rom_sz = ROM_SIZE_W'(1) << $urandom_range(10, 23);
      endcase
      case (phase % 5)
        0: sram_sz = '0;
        1: sram_sz = 18'h2_0000;
        2: sram_sz = 18'h3_FFFF;
        3: sram_sz = 18'h1;
        default: sram_sz = SRAM_SIZE_W'($urandom_range(1, 18'h2_0000));
      endcase
      // A write past the register map must leave the layout untouched
      if (phase == 1) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      configure(map_e'(phase % 4), rom_sz, sram_sz);

      // One phase runs flat out; another holds the sink off while the
      // driver keeps offering, so the pipeline fills and stalls its input
      src_idle_pct  = (phase == 3 || phase == 5) ? 0 : 9;
      sink_idle_pct = (phase == 3) ? 0 : 9;
      if (phase == 5) stall_req++;

      repeat (110)
        push_access(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ, rand_address());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_decodes.size() != 0) begin
      $error("%0d expected responses never arrived", expected_decodes.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("cartridge_address_mapper: match");
    end else begin
      $display("cartridge_address_mapper: mismatch");
    end
    $finish;
  end

endmodule
